[src/polynomial_arithmetic_unit_top_defines.svh]
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit assertion macros
// Concurrent assertion wrappers on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define POLYNOMIAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PAU_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PAU_ASSERT(lbl, prop, msg)
`define PAU_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

[src/pau_pkg.sv]
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit package
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pau_pkg;

  localparam int MaxDegree = 15;
  localparam int Depth     = MaxDegree + 1;
  localparam int AddrW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int IdxW      = $clog2(2 * MaxDegree + 1);
  localparam int CoefW     = 32;
  localparam int CoefIdxW  = 4;
  localparam int DegW      = 4;
  localparam int OutIdxW   = 5;
  localparam int ActW      = 2;
  localparam int CfgIdxW   = 2;
  localparam int InDataW   = ((CoefIdxW + CoefW + 7) / 8) * 8;
  localparam int OutDataW  = ((OutIdxW + CoefW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpSub    = 2'd1,
    OpMul    = 2'd2,
    OpHorner = 2'd3
  } op_e;

  typedef enum logic [ActW-1:0] {
    ActLoadA   = 2'd0,
    ActLoadB   = 2'd1,
    ActCompute = 2'd2
  } act_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOpMode    = 2'd0,
    CfgDegreeA   = 2'd1,
    CfgDegreeB   = 2'd2,
    CfgEvalPoint = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    AccAdd,
    AccSub,
    AccMac,
    AccProd,
    AccSum
  } acc_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StSum,
    StMul,
    StAcc,
    StEmit
  } state_e;

  typedef struct packed {
    logic               wr_a;
    logic               wr_b;
    logic               rd;
    logic [AddrW-1:0]   rd_addr_a;
    logic [AddrW-1:0]   rd_addr_b;
    logic               rd_ok_a;
    logic               rd_ok_b;
    logic               sum;
    logic               sum_first;
    logic               mul;
    logic               mul_horner;
    logic               acc;
    acc_e               acc_sel;
    logic               emit;
    logic [OutIdxW-1:0] emit_idx;
    logic               emit_last;
  } cmd_t;

  typedef struct packed {
    op_e              mode;
    logic [AddrW-1:0] deg_a;
    logic [AddrW-1:0] deg_b;
    logic             out_free;
  } sts_t;

  function automatic logic [AddrW-1:0] clamp_deg(logic [DegW-1:0] d);
    if (32'(d) > 32'(MaxDegree)) begin
      return AddrW'(MaxDegree);
    end
    return AddrW'(d);
  endfunction

endpackage

[src/polynomial_arithmetic_unit_top.sv]
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit
// Coefficient stores A and B with add, subtract, multiply and Horner evaluate.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the action (load A, load B, compute), tdata
//   the coefficient index and value.
//   A compute item runs op_mode over the stores; results leave on the output
//   stream from power 0 upward, tlast on the final item.
//   Config channel: write registers only while no compute is in progress;
//   cfg_ready_o is always high.
//   Per compute (a single shared multiplier and one read port per store set
//   the pace): add/subtract reads, combines and emits each result
//   coefficient; multiply reads, multiplies and accumulates each product
//   term, then emits each result coefficient; Horner reads, sums, multiplies
//   and accumulates per degree. Input tready stays low for the whole compute.
//   The output register holds an item until m_axis_tready; while it is held
//   the sequencer waits at the next emission.
//   Reset clears config registers to zero and the control state; store
//   contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module polynomial_arithmetic_unit_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pau_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pau_pkg::CoefW-1:0]        cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pau_pkg::InDataW-1:0]      s_axis_tdata,  // coef_index, coef_value
  input  logic [pau_pkg::ActW-1:0]         s_axis_tuser,  // action
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pau_pkg::OutDataW-1:0]     m_axis_tdata,  // out_index, out_value
  output logic                             m_axis_tlast
);

  pau_pkg::cmd_t                 cmd;
  pau_pkg::sts_t                 sts;
  logic [pau_pkg::OutIdxW-1:0]   out_index;
  logic [pau_pkg::CoefW-1:0]     out_value;

  assign cfg_ready_o = 1'b1;

  pau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pau_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .coef_index_i (s_axis_tdata[pau_pkg::CoefIdxW-1:0]),
    .coef_value_i (s_axis_tdata[pau_pkg::CoefIdxW +: pau_pkg::CoefW]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_index_o  (out_index),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = pau_pkg::OutDataW'({out_value, out_index});

endmodule

[src/pau_dp.sv]
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit datapath
// Config registers, coefficient stores, shared multiplier, accumulator and
// output register.
// ----------------------------------------------------------------------------
module pau_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [pau_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pau_pkg::CoefW-1:0]        cfg_data_i,
  input  logic [pau_pkg::CoefIdxW-1:0]     coef_index_i,
  input  logic [pau_pkg::CoefW-1:0]        coef_value_i,
  input  pau_pkg::cmd_t                    cmd_i,
  output pau_pkg::sts_t                    sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pau_pkg::OutIdxW-1:0]      out_index_o,
  output logic [pau_pkg::CoefW-1:0]        out_value_o,
  output logic                             out_last_o
);

  logic [pau_pkg::CoefW-1:0]    store_a_q [pau_pkg::Depth];
  logic [pau_pkg::CoefW-1:0]    store_b_q [pau_pkg::Depth];
  logic [pau_pkg::CoefW-1:0]    rd_a_q, rd_b_q;
  logic                         ok_a_q, ok_b_q;
  logic [pau_pkg::CoefW-1:0]    ta, tb;
  logic [pau_pkg::CoefW-1:0]    sum_q, prod_q, acc_q, acc_d;
  logic [pau_pkg::CoefW-1:0]    mul_a, mul_b;
  pau_pkg::op_e                 mode_q;
  logic [pau_pkg::DegW-1:0]     deg_a_q, deg_b_q;
  logic [pau_pkg::CoefW-1:0]    point_q;
  logic                         out_valid_q;
  logic [pau_pkg::OutIdxW-1:0]  out_index_q;
  logic [pau_pkg::CoefW-1:0]    out_value_q;
  logic                         out_last_q;
  logic                         idx_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pau_pkg::OpAdd;
      deg_a_q <= '0;
      deg_b_q <= '0;
      point_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (pau_pkg::cfg_e'(cfg_index_i))
        pau_pkg::CfgOpMode:    mode_q  <= pau_pkg::op_e'(cfg_data_i[1:0]);
        pau_pkg::CfgDegreeA:   deg_a_q <= cfg_data_i[pau_pkg::DegW-1:0];
        pau_pkg::CfgDegreeB:   deg_b_q <= cfg_data_i[pau_pkg::DegW-1:0];
        pau_pkg::CfgEvalPoint: point_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign idx_ok = 32'(coef_index_i) <= 32'(pau_pkg::MaxDegree);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a && idx_ok) begin
      store_a_q[pau_pkg::AddrW'(coef_index_i)] <= coef_value_i;
    end
    if (cmd_i.rd) begin
      rd_a_q <= store_a_q[cmd_i.rd_addr_a];
      ok_a_q <= cmd_i.rd_ok_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b && idx_ok) begin
      store_b_q[pau_pkg::AddrW'(coef_index_i)] <= coef_value_i;
    end
    if (cmd_i.rd) begin
      rd_b_q <= store_b_q[cmd_i.rd_addr_b];
      ok_b_q <= cmd_i.rd_ok_b;
    end
  end

  assign ta    = ok_a_q ? rd_a_q : '0;
  assign tb    = ok_b_q ? rd_b_q : '0;
  assign mul_a = cmd_i.mul_horner ? sum_q : ta;
  assign mul_b = cmd_i.mul_horner ? point_q : tb;

  always_comb begin
    unique case (cmd_i.acc_sel)
      pau_pkg::AccAdd:  acc_d = ta + tb;
      pau_pkg::AccSub:  acc_d = ta - tb;
      pau_pkg::AccMac:  acc_d = acc_q + prod_q;
      pau_pkg::AccProd: acc_d = prod_q;
      pau_pkg::AccSum:  acc_d = sum_q;
      default:          acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      sum_q <= cmd_i.sum_first ? ta : acc_q + ta;
    end
    if (cmd_i.mul) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_index_q <= cmd_i.emit_idx;
      out_value_q <= acc_q;
      out_last_q  <= cmd_i.emit_last;
    end
  end

  assign sts_o.mode     = mode_q;
  assign sts_o.deg_a    = pau_pkg::clamp_deg(deg_a_q);
  assign sts_o.deg_b    = pau_pkg::clamp_deg(deg_b_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

[src/pau_ctrl.sv]
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit controller
// Sequences loads, term reads, multiply-accumulate steps and result emission.
// ----------------------------------------------------------------------------
`include "polynomial_arithmetic_unit_top_defines.svh"

module pau_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pau_pkg::ActW-1:0]     action_i,
  input  pau_pkg::sts_t                sts_i,
  output pau_pkg::cmd_t                cmd_o
);

  pau_pkg::state_e               state_q, state_d;
  logic [pau_pkg::IdxW-1:0]      i_q, i_d;
  logic [pau_pkg::AddrW-1:0]     j_q, j_d;
  logic                          first_q, first_d;
  logic [pau_pkg::IdxW-1:0]      da_w, db_w, top, jhi, i_nxt, jlo_nxt, k_w;
  logic                          is_last;

  assign da_w    = pau_pkg::IdxW'(sts_i.deg_a);
  assign db_w    = pau_pkg::IdxW'(sts_i.deg_b);
  assign top     = (sts_i.mode == pau_pkg::OpMul) ? da_w + db_w
                 : ((da_w > db_w) ? da_w : db_w);
  assign jhi     = (i_q < da_w) ? i_q : da_w;
  assign i_nxt   = i_q + 1'b1;
  assign jlo_nxt = (i_nxt > db_w) ? i_nxt - db_w : '0;
  assign k_w     = i_q - pau_pkg::IdxW'(j_q);
  assign is_last = (sts_i.mode == pau_pkg::OpHorner) || (i_q == top);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pau_pkg::StIdle;
      i_q     <= '0;
      j_q     <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      first_q <= first_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    first_d    = first_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.acc_sel  = pau_pkg::AccAdd;
    cmd_o.emit_idx = pau_pkg::OutIdxW'(i_q);
    cmd_o.emit_last = is_last;
    unique case (state_q)
      pau_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (pau_pkg::act_e'(action_i))
            pau_pkg::ActLoadA: cmd_o.wr_a = 1'b1;
            pau_pkg::ActLoadB: cmd_o.wr_b = 1'b1;
            pau_pkg::ActCompute: begin
              i_d     = (sts_i.mode == pau_pkg::OpHorner) ? da_w : '0;
              j_d     = '0;
              first_d = 1'b1;
              state_d = pau_pkg::StRead;
            end
            default: ;
          endcase
        end
      end
      pau_pkg::StRead: begin
        cmd_o.rd = 1'b1;
        unique case (sts_i.mode)
          pau_pkg::OpMul: begin
            cmd_o.rd_addr_a = j_q;
            cmd_o.rd_addr_b = pau_pkg::AddrW'(k_w);
            cmd_o.rd_ok_a   = 1'b1;
            cmd_o.rd_ok_b   = 1'b1;
            state_d         = pau_pkg::StMul;
          end
          pau_pkg::OpHorner: begin
            cmd_o.rd_addr_a = pau_pkg::AddrW'(i_q);
            cmd_o.rd_ok_a   = 1'b1;
            state_d         = pau_pkg::StSum;
          end
          default: begin
            cmd_o.rd_addr_a = pau_pkg::AddrW'(i_q);
            cmd_o.rd_addr_b = pau_pkg::AddrW'(i_q);
            cmd_o.rd_ok_a   = i_q <= da_w;
            cmd_o.rd_ok_b   = i_q <= db_w;
            state_d         = pau_pkg::StAcc;
          end
        endcase
      end
      pau_pkg::StSum: begin
        cmd_o.sum       = 1'b1;
        cmd_o.sum_first = first_q;
        first_d         = 1'b0;
        state_d         = (i_q == '0) ? pau_pkg::StAcc : pau_pkg::StMul;
      end
      pau_pkg::StMul: begin
        cmd_o.mul        = 1'b1;
        cmd_o.mul_horner = sts_i.mode == pau_pkg::OpHorner;
        state_d          = pau_pkg::StAcc;
      end
      pau_pkg::StAcc: begin
        cmd_o.acc = 1'b1;
        unique case (sts_i.mode)
          pau_pkg::OpAdd: begin
            cmd_o.acc_sel = pau_pkg::AccAdd;
            state_d       = pau_pkg::StEmit;
          end
          pau_pkg::OpSub: begin
            cmd_o.acc_sel = pau_pkg::AccSub;
            state_d       = pau_pkg::StEmit;
          end
          pau_pkg::OpMul: begin
            cmd_o.acc_sel = first_q ? pau_pkg::AccProd : pau_pkg::AccMac;
            first_d       = 1'b0;
            if (pau_pkg::IdxW'(j_q) == jhi) begin
              state_d = pau_pkg::StEmit;
            end else begin
              j_d     = j_q + 1'b1;
              state_d = pau_pkg::StRead;
            end
          end
          default: begin
            if (i_q == '0) begin
              cmd_o.acc_sel = pau_pkg::AccSum;
              state_d       = pau_pkg::StEmit;
            end else begin
              cmd_o.acc_sel = pau_pkg::AccProd;
              i_d           = i_q - 1'b1;
              state_d       = pau_pkg::StRead;
            end
          end
        endcase
      end
      pau_pkg::StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (is_last) begin
            state_d = pau_pkg::StIdle;
          end else begin
            i_d     = i_nxt;
            j_d     = pau_pkg::AddrW'(jlo_nxt);
            first_d = 1'b1;
            state_d = pau_pkg::StRead;
          end
        end
      end
      default: state_d = pau_pkg::StIdle;
    endcase
  end

  `PAU_ASSERT(a_emit_free, cmd_o.emit |-> sts_i.out_free,
              "emit into occupied output register")
  `PAU_ASSERT(a_last_idle,
              (cmd_o.emit && cmd_o.emit_last) |=> (state_q == pau_pkg::StIdle),
              "no return to idle after last item")
  `PAU_ASSERT(a_i_range,
              ((state_q != pau_pkg::StIdle) && (sts_i.mode != pau_pkg::OpHorner))
              |-> (i_q <= top),
              "term power beyond top")
  `PAU_ASSERT(a_j_range,
              (state_q != pau_pkg::StIdle) |-> (pau_pkg::IdxW'(j_q) <= da_w),
              "A index beyond degree")
  `PAU_ASSERT_NEVER(a_store_clash, cmd_o.rd && (cmd_o.wr_a || cmd_o.wr_b),
                    "store write during compute")

endmodule
